// ===== sv/bmcb_pkg.sv =====
// Shared types and constants for the blockwise mean confidence bound unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package bmcb_pkg;

    localparam int DEF_MAX_BLOCKS = 256;
    localparam int DEF_MAX_LENGTH = 4096;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BLOCK_OVF = 2'd1;
    localparam logic [1:0] ST_LEN_OVF   = 2'd2;

    localparam logic [16:0] UNIT = 17'd65536;

    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,
        K_SAMPLE = 2'd1,
        K_RUN    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] const_index;
        logic [19:0] const_value;
        logic [16:0] sample;
        logic        opens;
    } t_item;

endpackage

// ===== sv/blockwise_mean_confidence_bound_unit.sv =====
// Top level of the blockwise mean confidence bound unit: config register,
// front stage, queue and back stage. Depends on bmcb_pkg and all bmcb_ modules.
//
// Usage: input beats carry an opcode (load constant, sample, new run) on
// i_valid/o_stall; each sample beat yields one result beat (bound, position,
// status) on o_valid/i_stall. Loads and new-run beats give no result.
// The direction register sits at byte address 0 of the APB-style port; write
// it only while the block is idle.
// Operation: a sample walks every open block in turn (memory read, length
// set-up, 29-step serial division, compare). The back stage takes no new
// item until the result of the last sample has entered the output register,
// so it does not start a new sample before the last one is done. Error
// samples (run or block overflow) skip the walk. Reset clears the block and
// run counters and the direction; block memories and the constant table are
// not cleared. A stalled receiver holds the result register; the queue keeps
// accepting beats until it and the front fill.
`timescale 1ns / 1ps
module blockwise_mean_confidence_bound_unit #(
    parameter int MAX_BLOCKS = bmcb_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_LENGTH = bmcb_pkg::DEF_MAX_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_const_index,
    input  logic [19:0] i_const_value,
    input  logic [16:0] i_sample,
    input  logic        i_opens_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_bound,
    output logic [11:0] o_position,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bmcb_pkg::*;

    logic  r_dir;
    logic  push, full, pop, empty;
    t_item f_item, q_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_dir} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_dir <= pwdata[0];
        end
    end

    bmcb_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_const_index,
        .i_const_value, .i_sample, .i_opens_block,
        .o_push(push), .o_item(f_item), .i_full(full)
    );

    bmcb_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_item(f_item), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_item(q_item)
    );

    bmcb_back #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_LENGTH(MAX_LENGTH)) u_back (
        .i_clk, .i_rst_n, .i_dir(r_dir), .i_empty(empty), .i_item(q_item),
        .o_pop(pop), .o_valid, .i_stall, .o_bound, .o_position, .o_status
    );

endmodule

// ===== sv/bmcb_front.sv =====
// Front stage: registers an input beat, saturates the sample, drops unused opcodes.
// Depends on bmcb_pkg; feeds bmcb_queue.
`timescale 1ns / 1ps
module bmcb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [11:0]        i_const_index,
    input  logic [19:0]        i_const_value,
    input  logic [16:0]        i_sample,
    input  logic               i_opens_block,
    output logic               o_push,
    output bmcb_pkg::t_item    o_item,
    input  logic               i_full
);
    import bmcb_pkg::*;

    logic  r_vld, n_vld;
    t_item r_item, n_item;
    logic  known;

    assign o_stall = r_vld && i_full;
    assign o_push  = r_vld && !i_full;
    assign o_item  = r_item;
    assign known   = (i_opcode == OP_LOAD) || (i_opcode == OP_SAMPLE) || (i_opcode == OP_RUN);

    always_comb begin
        n_vld  = r_vld && i_full;
        n_item = r_item;
        if (i_valid && !o_stall) begin
            n_vld              = known;
            n_item.kind        = t_kind'(i_opcode);
            n_item.const_index = i_const_index;
            n_item.const_value = i_const_value;
            n_item.sample      = (i_sample > UNIT) ? UNIT : i_sample;
            n_item.opens       = i_opens_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_item <= n_item;
    end

endmodule

// ===== sv/bmcb_queue.sv =====
// Two-entry queue between the front and back stages.
// Depends on bmcb_pkg for the item type.
`timescale 1ns / 1ps
module bmcb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bmcb_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output bmcb_pkg::t_item o_item
);
    import bmcb_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ===== sv/bmcb_back.sv =====
// Back stage: block memories, constant table, serial divider and bound sequencer.
// Depends on bmcb_pkg; pops items from bmcb_queue.
`timescale 1ns / 1ps
module bmcb_back #(
    parameter int MAX_BLOCKS = bmcb_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_LENGTH = bmcb_pkg::DEF_MAX_LENGTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_dir,
    input  logic            i_empty,
    input  bmcb_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [16:0]     o_bound,
    output logic [11:0]     o_position,
    output logic [1:0]      o_status
);
    import bmcb_pkg::*;

    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = $clog2(MAX_LENGTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_LEN  = 5'b00100,
        S_DIV  = 5'b01000,
        S_ACC  = 5'b10000
    } t_state;

    logic [28:0] r_sum_mem   [MAX_BLOCKS];
    logic [11:0] r_start_mem [MAX_BLOCKS];
    logic [19:0] r_ctab      [4096];

    t_state             r_st;
    logic               r_done;
    logic [CW-1:0]      r_open, r_j;
    logic [PW-1:0]      r_pos;
    logic [PW+11:0]     pos_ext;
    logic [11:0]        pos12;
    logic [16:0]        r_s;
    logic               r_up;
    logic [11:0]        r_item_pos, r_diff;
    logic signed [30:0] r_best, v;
    logic [1:0]         r_stat;
    logic [28:0]        r_sum_q, r_quo, new_sum;
    logic [11:0]        r_start_q;
    logic [19:0]        r_c_q;
    logic [12:0]        r_rem, r_den;
    logic [13:0]        trial;
    logic [4:0]         r_cnt;
    logic               r_ovld;
    logic [16:0]        r_obound;
    logic [11:0]        r_opos;
    logic [1:0]         r_ostat;
    logic               take, opening, out_free;
    logic [16:0]        clamped;

    assign pos_ext  = {12'd0, r_pos};
    assign pos12    = pos_ext[11:0];
    assign take     = (r_st == S_IDLE) && !r_done && !i_empty;
    assign o_pop    = take;
    assign opening  = i_item.opens || (r_open == '0);
    assign out_free = !r_ovld || !i_stall;
    assign new_sum  = r_sum_q + {12'd0, r_s};
    assign trial    = {r_rem, r_quo[28]};
    assign v = r_up ? ($signed({2'b00, r_quo}) + $signed({11'd0, r_c_q}))
                    : ($signed({2'b00, r_quo}) - $signed({11'd0, r_c_q}));

    always_comb begin
        if (r_best < 0)                              clamped = 17'd0;
        else if (r_best > $signed({14'd0, UNIT}))    clamped = UNIT;
        else                                         clamped = r_best[16:0];
    end

    assign o_valid    = r_ovld;
    assign o_bound    = r_obound;
    assign o_position = r_opos;
    assign o_status   = r_ostat;

    // memories: registered reads, one write port each
    always_ff @(posedge i_clk) begin
        r_sum_q   <= r_sum_mem[r_j[BW-1:0]];
        r_start_q <= r_start_mem[r_j[BW-1:0]];
        r_c_q     <= r_ctab[r_diff];
        if (take && i_item.kind == K_LOAD)
            r_ctab[i_item.const_index] <= i_item.const_value;
        if (take && i_item.kind == K_SAMPLE && opening && r_pos < PW'(MAX_LENGTH)
            && r_open < CW'(MAX_BLOCKS)) begin
            r_sum_mem[r_open[BW-1:0]]   <= 29'd0;
            r_start_mem[r_open[BW-1:0]] <= pos12;
        end else if (r_st == S_LEN) begin
            r_sum_mem[r_j[BW-1:0]] <= new_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_done <= 1'b0;
            r_open <= '0;
            r_pos  <= '0;
            r_ovld <= 1'b0;
        end else begin
            // hold the finished result until the output register frees
            if (r_done && out_free) begin
                r_ovld   <= 1'b1;
                r_obound <= clamped;
                r_opos   <= r_item_pos;
                r_ostat  <= r_stat;
                r_done   <= 1'b0;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (take) begin
                        unique case (i_item.kind)
                            K_LOAD: ;
                            K_RUN: begin
                                r_open <= '0;
                                r_pos  <= '0;
                            end
                            K_SAMPLE: begin
                                r_s        <= i_item.sample;
                                r_up       <= i_dir;
                                r_item_pos <= pos12;
                                r_j        <= '0;
                                r_best     <= i_dir ? $signed({14'd0, UNIT}) : 31'sd0;
                                if (r_pos >= PW'(MAX_LENGTH)) begin
                                    r_stat <= ST_LEN_OVF;
                                    r_done <= 1'b1;
                                end else if (opening && r_open >= CW'(MAX_BLOCKS)) begin
                                    r_stat <= ST_BLOCK_OVF;
                                    r_done <= 1'b1;
                                end else begin
                                    r_stat <= ST_OK;
                                    r_pos  <= r_pos + 1'b1;
                                    if (opening) r_open <= r_open + 1'b1;
                                    r_st <= S_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: r_st <= S_LEN;
                S_LEN: begin
                    // item position is r_item_pos; r_pos has already advanced
                    r_diff <= r_item_pos - r_start_q;
                    r_den  <= {1'b0, r_item_pos - r_start_q} + 13'd1;
                    r_quo  <= new_sum;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_st   <= S_DIV;
                end
                S_DIV: begin
                    if (trial >= {1'b0, r_den}) begin
                        r_rem <= 13'(trial - {1'b0, r_den});
                        r_quo <= {r_quo[27:0], 1'b1};
                    end else begin
                        r_rem <= trial[12:0];
                        r_quo <= {r_quo[27:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd28) r_st <= S_ACC;
                end
                S_ACC: begin
                    if (r_up ? (v < r_best) : (v > r_best)) r_best <= v;
                    if (r_j + 1'b1 == r_open) begin
                        r_done <= 1'b1;
                        r_st   <= S_IDLE;
                    end else begin
                        r_j  <= r_j + 1'b1;
                        r_st <= S_RD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for blockwise_mean_confidence_bound_unit.
// Drives constant loads, runs and samples, predicts each bound in fixed point.
// Depends on bmcb_pkg and the unit's RTL.
`timescale 1ns / 1ps
module testbench;
    import bmcb_pkg::*;

    localparam int          NBLK      = DEF_MAX_BLOCKS;
    localparam int          NLEN      = DEF_MAX_LENGTH;
    localparam logic [1:0]  OP_SPARE  = 2'd3;
    localparam logic [2:0]  ADDR_DIR  = 3'd0;
    localparam longint      CYCLE_CAP = 20000000;

    typedef struct {
        logic [16:0] bound;
        logic [11:0] position;
        logic [1:0]  status;
    } t_bound_beat;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall;
    logic [1:0]  i_opcode;
    logic [11:0] i_const_index;
    logic [19:0] i_const_value;
    logic [16:0] i_sample;
    logic        i_opens_block;
    logic        o_valid, i_stall;
    logic [16:0] o_bound;
    logic [11:0] o_position;
    logic [1:0]  o_status;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    // predictor state
    logic [28:0] blk_sum [NBLK];
    logic [11:0] blk_start [NBLK];
    int unsigned blk_open;
    int unsigned run_pos;
    logic [19:0] band_table [4096];
    logic        upper_mode;

    t_bound_beat bound_q[$];
    int          err_count;
    int          send_idle, recv_idle;
    int          hold_cycles;
    longint      cycle_count;

    blockwise_mean_confidence_bound_unit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("[blockwise_mean_confidence_bound_unit] ERROR");
            $finish;
        end
    end

    // receiver: random stall, plus a counted hold-off when asked
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_bound_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (bound_q.size() == 0) begin
                report_mismatch("unexpected beat, position", o_position, 0);
            end else begin
                want = bound_q.pop_front();
                if (o_bound !== want.bound) report_mismatch("bound", o_bound, want.bound);
                if (o_position !== want.position)
                    report_mismatch("position", o_position, want.position);
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
            end
        end
    end

    task automatic predict_bound(input logic [1:0] op, input logic [11:0] idx,
                                 input logic [19:0] val, input logic [16:0] smp,
                                 input logic opn);
        t_bound_beat r;
        logic [16:0] s;
        logic [12:0] len;
        logic [16:0] neutral;
        bit          opening;
        longint      best, v, mean;
        case (op)
            OP_LOAD: begin
                band_table[idx] = val;
            end
            OP_RUN: begin
                blk_open = 0;
                run_pos = 0;
            end
            OP_SAMPLE: begin
                s = (smp > UNIT) ? UNIT : smp;
                neutral = upper_mode ? UNIT : 17'd0;
                opening = opn || blk_open == 0;
                r.position = run_pos[11:0];
                r.bound = neutral;
                if (run_pos >= NLEN) begin
                    r.status = ST_LEN_OVF;
                end else if (opening && blk_open >= NBLK) begin
                    r.status = ST_BLOCK_OVF;
                end else begin
                    if (opening) begin
                        blk_sum[blk_open] = '0;
                        blk_start[blk_open] = run_pos[11:0];
                        blk_open++;
                    end
                    best = upper_mode ? longint'(UNIT) : 0;
                    for (int j = 0; j < blk_open; j++) begin
                        len = {1'b0, run_pos[11:0] - blk_start[j]} + 13'd1;
                        blk_sum[j] = blk_sum[j] + s;
                        mean = blk_sum[j] / len;
                        if (upper_mode) begin
                            v = mean + band_table[len[11:0] - 12'd1];
                            if (v < best) best = v;
                        end else begin
                            v = mean - band_table[len[11:0] - 12'd1];
                            if (v > best) best = v;
                        end
                    end
                    if (best < 0) best = 0;
                    if (best > UNIT) best = UNIT;
                    r.bound = best[16:0];
                    r.status = ST_OK;
                    run_pos++;
                end
                bound_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [1:0] op, input logic [11:0] idx,
                             input logic [19:0] val, input logic [16:0] smp,
                             input logic opn);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_const_index <= idx;
        i_const_value <= val;
        i_sample <= smp;
        i_opens_block <= opn;
        do @(posedge i_clk); while (o_stall);
        predict_bound(op, idx, val, smp, opn);
        @(negedge i_clk);
    endtask

    task automatic send_sample(input logic [16:0] smp, input logic opn);
        send_item(OP_SAMPLE, 12'($urandom), 20'($urandom), smp, opn);
    endtask

    task automatic send_run();
        send_item(OP_RUN, 12'($urandom), 20'($urandom), 17'($urandom), 1'($urandom));
    endtask

    function automatic logic [16:0] rand_sample();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return UNIT;
            2: return 17'($urandom);
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    // drain and let trailing loads finish before touching the register
    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (bound_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_direction(input logic dir);
        wait_quiet();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_DIR;
        pwdata <= {31'($urandom), dir};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        upper_mode = dir;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // runs stay well below 512 samples, so only the low entries are read
    task automatic test_table_load();
        send_item(OP_LOAD, 12'd0, 20'd0, 17'd0, 1'b0);
        send_item(OP_LOAD, 12'd4095, 20'hFFFFF, 17'd0, 1'b0);
        for (int i = 0; i < 512; i++)
            send_item(OP_LOAD, 12'(i),
                      ($urandom_range(15) == 0) ? 20'($urandom) : 20'($urandom_range(6000)),
                      17'($urandom), 1'($urandom));
    endtask

    task automatic test_directed();
        send_run();
        send_sample(17'd40000, 1'b0);        // no block open: opens one anyway
        send_sample(17'd0, 1'b0);
        send_sample(UNIT, 1'b1);
        send_sample(17'h1FFFF, 1'b0);        // above one: saturates
        send_item(OP_SPARE, 12'hFFF, 20'hFFFFF, 17'h1FFFF, 1'b1);
        send_sample(17'd32768, 1'b1);
        send_item(OP_LOAD, 12'd2, 20'd0, 17'd0, 1'b0);
        send_sample(17'd65535, 1'b0);
        write_direction(1'b1);
        send_sample(17'd100, 1'b0);          // same run, now upper mode
        send_sample(17'd0, 1'b1);
        send_run();
        send_sample(UNIT, 1'b0);
        send_sample(17'h10001, 1'b1);
        send_sample(17'd1, 1'b0);
        write_direction(1'b0);
    endtask

    task automatic test_block_overflow();
        send_run();
        for (int i = 0; i < NBLK + 2; i++) send_sample(rand_sample(), 1'b1);
        send_sample(rand_sample(), 1'b0);
        send_run();
    endtask

    task automatic test_random_runs(input int items, input bit pressure);
        int n = 0;
        int run_len;
        while (n < items) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(2))
                    0: send_item(OP_SPARE, 12'($urandom), 20'($urandom),
                                 17'($urandom), 1'($urandom));
                    1: send_item(OP_LOAD, 12'($urandom), 20'($urandom_range(6000)),
                                 17'($urandom), 1'($urandom));
                    default: send_sample(rand_sample(), 1'($urandom));
                endcase
                n++;
            end else begin
                send_run();
                run_len = $urandom_range(1, 40);
                for (int k = 0; k < run_len; k++)
                    send_sample(rand_sample(), ($urandom_range(4) == 0));
                n += run_len + 1;
            end
            if (pressure && n > items / 3) begin
                pressure = 0;
                hold_cycles = 3000;
                for (int k = 0; k < 60; k++) send_sample(rand_sample(), ($urandom_range(9) == 0));
                // pause until every result is back
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (bound_q.size() != 0) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_opcode = OP_LOAD;
        i_const_index = '0;
        i_const_value = '0;
        i_sample = '0;
        i_opens_block = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        blk_open = 0;
        run_pos = 0;
        upper_mode = 1'b0;
        err_count = 0;
        hold_cycles = 0;
        cycle_count = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_table_load();
        test_directed();
        test_block_overflow();
        write_direction(1'b1);

        send_idle = 17;
        recv_idle = 65;
        test_random_runs(130, 1'b1);
        write_direction(1'b0);
        send_idle = 65;
        recv_idle = 17;
        test_random_runs(130, 1'b0);
        write_direction(1'b1);
        send_idle = 0;
        recv_idle = 0;
        test_random_runs(130, 1'b0);

        wait_quiet();
        if (err_count == 0 && bound_q.size() == 0) begin
            $display("[blockwise_mean_confidence_bound_unit] OK");
        end else begin
            $display("[blockwise_mean_confidence_bound_unit] ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/bmcb_pkg.sv
sv/bmcb_front.sv
sv/bmcb_queue.sv
sv/bmcb_back.sv
sv/blockwise_mean_confidence_bound_unit.sv
tb/testbench.sv
